// ----- rtl/hcpu_pkg.sv -----
// Shared types and constants for the hex accumulator processor step block.
package hcpu_pkg;

  // Word address width of the instruction/data store
  localparam int unsigned WORD_ADDR_BITS = 15;

  // Instruction opcodes (high nibble of the instruction byte)
  typedef enum logic [3:0] {
    OP_LDAM = 4'h0,
    OP_LDBM = 4'h1,
    OP_STAM = 4'h2,
    OP_LDAC = 4'h3,
    OP_LDBC = 4'h4,
    OP_LDAP = 4'h5,
    OP_LDAI = 4'h6,
    OP_LDBI = 4'h7,
    OP_STBI = 4'h8,
    OP_BR   = 4'h9,
    OP_BRZ  = 4'hA,
    OP_BRN  = 4'hB,
    OP_BRB  = 4'hC,
    OP_OPR  = 4'hD,
    OP_PFIX = 4'hE,
    OP_NFIX = 4'hF
  } hcpu_op_e;

  // Operand codes of the opr instruction
  localparam logic [15:0] OPR_ADD = 16'd0;
  localparam logic [15:0] OPR_SUB = 16'd1;
  localparam logic [15:0] OPR_IN  = 16'd2;
  localparam logic [15:0] OPR_OUT = 16'd3;

  // Upper byte forced by a negative prefix
  localparam logic [15:0] NFIX_MASK = 16'hFF00;

  // Item operation codes
  localparam logic OPN_LOAD = 1'b0;
  localparam logic OPN_EXEC = 1'b1;

  // One result transaction
  typedef struct packed {
    logic [15:0] pc;
    logic [15:0] acc;
    logic        out_valid;
    logic [7:0]  out_byte;
    logic [15:0] io_port;
    logic        in_taken;
  } hcpu_res_t;

endpackage

// ----- rtl/hex_cpu_instruction_step_top.sv -----
// Top level: processor core plus a two-entry result buffer on the output side.
// Load items write the store and are taken one per cycle while the spare entry is
// empty. An execute item passes the fetch state, then the data state when it reads
// a data word (ldam, ldbm, ldai, ldbi); no new item is taken until it is done, as the
// single port of the word store serves the fetch, then the data read or write.
// Reset clears pc, A, B, the operand register and the buffers; the store is not cleared.
module hex_cpu_instruction_step_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [14:0] load_addr_i,
  input  logic [15:0] load_data_i,
  input  logic [15:0] in_data_i,
  output logic        res_valid_o,
  input  logic        res_stall_i,
  output logic [15:0] pc_now_o,
  output logic [15:0] acc_now_o,
  output logic        out_valid_o,
  output logic [7:0]  out_byte_o,
  output logic [15:0] io_port_o,
  output logic        in_taken_o
);

  logic                fin;
  hcpu_pkg::hcpu_res_t fin_res;
  logic                out_vld_q;
  hcpu_pkg::hcpu_res_t out_q;
  logic                spr_vld_q;
  hcpu_pkg::hcpu_res_t spr_q;
  logic                out_free;

  hcpu_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .operation_i(operation_i),
    .load_addr_i(load_addr_i),
    .load_data_i(load_data_i),
    .in_data_i  (in_data_i),
    .room_i     (!spr_vld_q),
    .fin_o      (fin),
    .res_o      (fin_res)
  );

  // Output register is free when empty or drained this cycle
  assign out_free = !out_vld_q || !res_stall_i;

  // Buffer occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      spr_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= spr_vld_q || fin;
      spr_vld_q <= spr_vld_q && fin;
    end else if (fin) begin
      spr_vld_q <= 1'b1;
    end
  end

  // Buffer payload; the spare entry is always older than a new result
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (spr_vld_q) begin
        out_q <= spr_q;
        if (fin) begin
          spr_q <= fin_res;
        end
      end else if (fin) begin
        out_q <= fin_res;
      end
    end else if (fin) begin
      spr_q <= fin_res;
    end
  end

  assign res_valid_o = out_vld_q;
  assign pc_now_o    = out_q.pc;
  assign acc_now_o   = out_q.acc;
  assign out_valid_o = out_q.out_valid;
  assign out_byte_o  = out_q.out_byte;
  assign io_port_o   = out_q.io_port;
  assign in_taken_o  = out_q.in_taken;

endmodule

// ----- rtl/hcpu_ram.sv -----
// Single-port synchronous RAM with registered read data.
module hcpu_ram #(
  parameter int unsigned DATA_W = 16,
  parameter int unsigned ADDR_W = 15
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic [DATA_W-1:0] rdata_o
);

  localparam int unsigned Depth = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [Depth];
  logic [DATA_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/hcpu_core.sv -----
// Fetch/execute sequencer with the register file around the word store.
module hcpu_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  operation_i,
  input  logic [14:0]           load_addr_i,
  input  logic [15:0]           load_data_i,
  input  logic [15:0]           in_data_i,
  input  logic                  room_i,
  output logic                  fin_o,
  output hcpu_pkg::hcpu_res_t   res_o
);

  localparam int unsigned W = hcpu_pkg::WORD_ADDR_BITS;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FETCH = 2'd1;
  localparam logic [1:0] ST_DATA  = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [15:0] pc_q, pc_d;
  logic [15:0] a_q, a_d;
  logic [15:0] b_q, b_d;
  logic [15:0] opr_q, opr_d;
  logic [15:0] in_data_q;
  logic        dst_b_q;

  logic          accept;
  logic          mem_we;
  logic [W-1:0]  mem_addr;
  logic [15:0]   mem_wdata;
  logic [15:0]   mem_rdata;

  // Decode signals
  logic [7:0]          ins;
  hcpu_pkg::hcpu_op_e  op;
  logic [15:0]         o;
  logic [15:0]         pc_inc;
  logic [15:0]         a_sum;
  logic [15:0]         b_sum;
  logic                go_data;
  logic                dst_b;
  hcpu_pkg::hcpu_res_t ex_res;
  logic [W-1:0]        ex_addr;
  logic                ex_we;

  assign in_stall_o = !((state_q == ST_IDLE) && room_i);
  assign accept     = in_valid_i && !in_stall_o;

  hcpu_ram #(
    .DATA_W(16),
    .ADDR_W(W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  // Instruction decode and execute, valid in the fetch state
  always_comb begin
    ins     = pc_q[0] ? mem_rdata[15:8] : mem_rdata[7:0];
    op      = hcpu_pkg::hcpu_op_e'(ins[7:4]);
    o       = opr_q | {12'd0, ins[3:0]};
    pc_inc  = pc_q + 16'd1;
    a_sum   = a_q + o;
    b_sum   = b_q + o;
    pc_d    = pc_inc;
    a_d     = a_q;
    b_d     = b_q;
    opr_d   = '0;
    go_data = 1'b0;
    dst_b   = 1'b0;
    ex_we   = 1'b0;
    ex_addr = o[W-1:0];
    ex_res  = '0;
    case (op)
      hcpu_pkg::OP_LDAM: go_data = 1'b1;
      hcpu_pkg::OP_LDBM: begin
        go_data = 1'b1;
        dst_b   = 1'b1;
      end
      hcpu_pkg::OP_STAM: ex_we = 1'b1;
      hcpu_pkg::OP_LDAC: a_d = o;
      hcpu_pkg::OP_LDBC: b_d = o;
      hcpu_pkg::OP_LDAP: a_d = pc_inc + o;
      hcpu_pkg::OP_LDAI: begin
        go_data = 1'b1;
        ex_addr = a_sum[W-1:0];
      end
      hcpu_pkg::OP_LDBI: begin
        go_data = 1'b1;
        dst_b   = 1'b1;
        ex_addr = b_sum[W-1:0];
      end
      hcpu_pkg::OP_STBI: begin
        ex_we   = 1'b1;
        ex_addr = b_sum[W-1:0];
      end
      hcpu_pkg::OP_BR:  pc_d = pc_inc + o;
      hcpu_pkg::OP_BRZ: begin
        if (a_q == 16'd0) begin
          pc_d = pc_inc + o;
        end
      end
      hcpu_pkg::OP_BRN: begin
        if (a_q[15]) begin
          pc_d = pc_inc + o;
        end
      end
      hcpu_pkg::OP_BRB: pc_d = b_sum;
      hcpu_pkg::OP_OPR: begin
        case (o)
          hcpu_pkg::OPR_ADD: a_d = a_q + b_q;
          hcpu_pkg::OPR_SUB: a_d = a_q - b_q;
          hcpu_pkg::OPR_IN: begin
            a_d             = in_data_q;
            ex_res.in_taken = 1'b1;
            ex_res.io_port  = b_q;
          end
          hcpu_pkg::OPR_OUT: begin
            ex_res.out_valid = 1'b1;
            ex_res.out_byte  = a_q[7:0];
            ex_res.io_port   = b_q;
          end
          // Unknown opr: operand register keeps the merged value
          default: opr_d = o;
        endcase
      end
      hcpu_pkg::OP_PFIX: opr_d = {o[11:0], 4'd0};
      hcpu_pkg::OP_NFIX: opr_d = hcpu_pkg::NFIX_MASK | {o[11:0], 4'd0};
      default: opr_d = '0;
    endcase
    ex_res.pc  = pc_d;
    ex_res.acc = a_d;
  end

  // Memory port steering
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = a_q;
    mem_addr  = pc_q[W:1];
    fin_o     = 1'b0;
    res_o     = '0;
    state_d   = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (operation_i == hcpu_pkg::OPN_LOAD) begin
            mem_we    = 1'b1;
            mem_addr  = load_addr_i[W-1:0];
            mem_wdata = load_data_i;
            fin_o     = 1'b1;
            res_o.pc  = pc_q;
            res_o.acc = a_q;
          end else begin
            state_d = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        mem_we   = ex_we;
        mem_addr = ex_addr;
        if (go_data) begin
          state_d = ST_DATA;
        end else begin
          state_d = ST_IDLE;
          fin_o   = 1'b1;
          res_o   = ex_res;
        end
      end
      ST_DATA: begin
        state_d   = ST_IDLE;
        fin_o     = 1'b1;
        res_o.pc  = pc_q;
        res_o.acc = dst_b_q ? a_q : mem_rdata;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state and architectural registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q    <= '0;
      a_q     <= '0;
      b_q     <= '0;
      opr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_FETCH) begin
        pc_q  <= pc_d;
        a_q   <= a_d;
        b_q   <= b_d;
        opr_q <= opr_d;
      end else if (state_q == ST_DATA) begin
        if (dst_b_q) begin
          b_q <= mem_rdata;
        end else begin
          a_q <= mem_rdata;
        end
      end
    end
  end

  // Item payload and data-read destination
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_data_q <= in_data_i;
    end
    if (state_q == ST_FETCH) begin
      dst_b_q <= dst_b;
    end
  end

endmodule

// ----- verif/tb_hex_cpu_instruction_step_top.sv -----
// Testbench for the hex accumulator processor step block: directed program, then random programs.
`timescale 1ns / 1ps

module tb_hex_cpu_instruction_step_top;

  localparam int unsigned STORE_DEPTH = 1 << hcpu_pkg::WORD_ADDR_BITS;
  localparam int DIR_ROWS = 27;
  localparam int PHASE_ITEMS = 170;
  localparam int STUCK_LIMIT = 2000;
  // Sender idle and receiver stall percentages per random phase
  localparam int SEND_IDLE [4] = '{0, 54, 0, 30};
  localparam int RECV_STALL [4] = '{0, 0, 54, 30};

  typedef logic [hcpu_pkg::WORD_ADDR_BITS-1:0] waddr_t;

  // One directed row; exp_pc/exp_acc are used only when typed is set
  typedef struct packed {
    logic        opn;
    logic [14:0] addr;
    logic [15:0] data;
    logic [15:0] in_val;
    logic        typed;
    logic [15:0] exp_pc;
    logic [15:0] exp_acc;
  } stim_row_t;

  // Program: ldac 15, nfix 15, stam (wraps to top word), nfix 15, ldbm (wraps),
  // add, sub, in (end of input), out, unknown opr, ldap, stbi, ldai, ldbi,
  // brz not taken, br over a byte, brb
  localparam stim_row_t DIR_TAB [DIR_ROWS] = '{
    {hcpu_pkg::OPN_LOAD, 15'h7FFF, 16'hFFFF, 16'h0000, 1'b1, 16'h0000, 16'h0000},
    {hcpu_pkg::OPN_LOAD, 15'h0000, 16'hFF3F, 16'hFFFF, 1'b1, 16'h0000, 16'h0000},
    {hcpu_pkg::OPN_LOAD, 15'h0001, 16'hFF2F, 16'h0000, 1'b1, 16'h0000, 16'h0000},
    {hcpu_pkg::OPN_LOAD, 15'h0002, 16'hD01F, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    {hcpu_pkg::OPN_LOAD, 15'h0003, 16'hD2D1, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    {hcpu_pkg::OPN_LOAD, 15'h0004, 16'hD7D3, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    {hcpu_pkg::OPN_LOAD, 15'h0005, 16'h8F50, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    {hcpu_pkg::OPN_LOAD, 15'h0006, 16'h7F6C, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    {hcpu_pkg::OPN_LOAD, 15'h0007, 16'h91A1, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    {hcpu_pkg::OPN_LOAD, 15'h0008, 16'hC200, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    {hcpu_pkg::OPN_EXEC, 15'h0000, 16'h0000, 16'h0000, 1'b1, 16'h0001, 16'h000F},
    {hcpu_pkg::OPN_EXEC, 15'h0000, 16'h0000, 16'h0000, 1'b1, 16'h0002, 16'h000F},
    {hcpu_pkg::OPN_EXEC, 15'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    {hcpu_pkg::OPN_EXEC, 15'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    {hcpu_pkg::OPN_EXEC, 15'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    {hcpu_pkg::OPN_EXEC, 15'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    {hcpu_pkg::OPN_EXEC, 15'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    {hcpu_pkg::OPN_EXEC, 15'h0000, 16'h0000, 16'hFFFF, 1'b0, 16'h0000, 16'h0000},
    {hcpu_pkg::OPN_EXEC, 15'h0000, 16'h0000, 16'h5A5A, 1'b0, 16'h0000, 16'h0000},
    {hcpu_pkg::OPN_EXEC, 15'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    {hcpu_pkg::OPN_EXEC, 15'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    {hcpu_pkg::OPN_EXEC, 15'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    {hcpu_pkg::OPN_EXEC, 15'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    {hcpu_pkg::OPN_EXEC, 15'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    {hcpu_pkg::OPN_EXEC, 15'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    {hcpu_pkg::OPN_EXEC, 15'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    {hcpu_pkg::OPN_EXEC, 15'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        operation_i = hcpu_pkg::OPN_LOAD;
  logic [14:0] load_addr_i = '0;
  logic [15:0] load_data_i = '0;
  logic [15:0] in_data_i = '0;
  logic        res_valid_o;
  logic        res_stall_i = 1'b0;
  logic [15:0] pc_now_o;
  logic [15:0] acc_now_o;
  logic        out_valid_o;
  logic [7:0]  out_byte_o;
  logic [15:0] io_port_o;
  logic        in_taken_o;

  // Processor state as the testbench sees it
  logic [15:0] mem_words [0:STORE_DEPTH-1];
  bit          mem_written [0:STORE_DEPTH-1];
  logic [15:0] cpu_pc = '0;
  logic [15:0] cpu_a = '0;
  logic [15:0] cpu_b = '0;
  logic [15:0] cpu_opnd = '0;

  hcpu_pkg::hcpu_res_t pending_results [$];
  int          errors = 0;
  int          items_sent = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          stuck_cycles = 0;

  hex_cpu_instruction_step_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .load_addr_i (load_addr_i),
    .load_data_i (load_data_i),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid_o),
    .res_stall_i (res_stall_i),
    .pc_now_o    (pc_now_o),
    .acc_now_o   (acc_now_o),
    .out_valid_o (out_valid_o),
    .out_byte_o  (out_byte_o),
    .io_port_o   (io_port_o),
    .in_taken_o  (in_taken_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void write_word(input waddr_t wa, input logic [15:0] val);
    mem_words[wa] = val;
    mem_written[wa] = 1'b1;
  endfunction

  // Instruction byte at the current pc; odd pc takes the high byte
  function automatic logic [7:0] fetch_byte();
    logic [15:0] w;
    w = mem_words[cpu_pc[hcpu_pkg::WORD_ADDR_BITS:1]];
    return cpu_pc[0] ? w[15:8] : w[7:0];
  endfunction

  // Word address read by this instruction, if it reads one
  function automatic bit reads_data(input logic [7:0] ins, output waddr_t wa);
    logic [15:0] o;
    logic [15:0] sum;
    bit          hit;
    o = cpu_opnd | {12'd0, ins[3:0]};
    wa = '0;
    hit = 1'b1;
    case (hcpu_pkg::hcpu_op_e'(ins[7:4]))
      hcpu_pkg::OP_LDAM, hcpu_pkg::OP_LDBM: wa = o[hcpu_pkg::WORD_ADDR_BITS-1:0];
      hcpu_pkg::OP_LDAI: begin
        sum = cpu_a + o;
        wa = sum[hcpu_pkg::WORD_ADDR_BITS-1:0];
      end
      hcpu_pkg::OP_LDBI: begin
        sum = cpu_b + o;
        wa = sum[hcpu_pkg::WORD_ADDR_BITS-1:0];
      end
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  // Advance the processor by one transaction and return its result
  function automatic hcpu_pkg::hcpu_res_t step_processor(input logic opn, input waddr_t la,
                                                         input logic [15:0] ld,
                                                         input logic [15:0] idata);
    hcpu_pkg::hcpu_res_t r;
    logic [7:0]  ins;
    logic [15:0] o;
    logic [15:0] rd_val;
    logic [15:0] sum;
    waddr_t      rd_wa;
    bit          keep;
    r = '0;
    keep = 1'b0;
    rd_val = '0;
    if (opn == hcpu_pkg::OPN_LOAD) begin
      write_word(la, ld);
    end else begin
      ins = fetch_byte();
      if (reads_data(ins, rd_wa)) rd_val = mem_words[rd_wa];
      cpu_pc = cpu_pc + 16'd1;
      cpu_opnd = cpu_opnd | {12'd0, ins[3:0]};
      o = cpu_opnd;
      case (hcpu_pkg::hcpu_op_e'(ins[7:4]))
        hcpu_pkg::OP_LDAM, hcpu_pkg::OP_LDAI: cpu_a = rd_val;
        hcpu_pkg::OP_LDBM, hcpu_pkg::OP_LDBI: cpu_b = rd_val;
        hcpu_pkg::OP_STAM: write_word(o[hcpu_pkg::WORD_ADDR_BITS-1:0], cpu_a);
        hcpu_pkg::OP_LDAC: cpu_a = o;
        hcpu_pkg::OP_LDBC: cpu_b = o;
        hcpu_pkg::OP_LDAP: cpu_a = cpu_pc + o;
        hcpu_pkg::OP_STBI: begin
          sum = cpu_b + o;
          write_word(sum[hcpu_pkg::WORD_ADDR_BITS-1:0], cpu_a);
        end
        hcpu_pkg::OP_BR: cpu_pc = cpu_pc + o;
        hcpu_pkg::OP_BRZ: if (cpu_a == 16'd0) cpu_pc = cpu_pc + o;
        hcpu_pkg::OP_BRN: if (cpu_a[15]) cpu_pc = cpu_pc + o;
        hcpu_pkg::OP_BRB: cpu_pc = cpu_b + o;
        hcpu_pkg::OP_OPR: begin
          if (o == hcpu_pkg::OPR_ADD) begin
            cpu_a = cpu_a + cpu_b;
          end else if (o == hcpu_pkg::OPR_SUB) begin
            cpu_a = cpu_a - cpu_b;
          end else if (o == hcpu_pkg::OPR_IN) begin
            cpu_a = idata;
            r.in_taken = 1'b1;
            r.io_port = cpu_b;
          end else if (o == hcpu_pkg::OPR_OUT) begin
            r.out_valid = 1'b1;
            r.out_byte = cpu_a[7:0];
            r.io_port = cpu_b;
          end else begin
            // unknown opr code: operand register is kept
            keep = 1'b1;
          end
        end
        hcpu_pkg::OP_PFIX: begin
          cpu_opnd = o << 4;
          keep = 1'b1;
        end
        hcpu_pkg::OP_NFIX: begin
          cpu_opnd = hcpu_pkg::NFIX_MASK | (o << 4);
          keep = 1'b1;
        end
        default: keep = 1'b0;
      endcase
      if (!keep) cpu_opnd = '0;
    end
    r.pc = cpu_pc;
    r.acc = cpu_a;
    return r;
  endfunction

  // Random instruction byte, biased toward prefixes and opr codes 0 to 3
  function automatic logic [7:0] pick_ins();
    int unsigned        roll;
    hcpu_pkg::hcpu_op_e opc;
    logic [3:0]         nib;
    roll = $urandom_range(99);
    nib = 4'($urandom);
    if (roll < 12) begin
      opc = hcpu_pkg::OP_PFIX;
    end else if (roll < 20) begin
      opc = hcpu_pkg::OP_NFIX;
    end else if (roll < 40) begin
      opc = hcpu_pkg::OP_OPR;
      if ($urandom_range(99) < 85) nib = 4'($urandom_range(3));
    end else begin
      opc = hcpu_pkg::hcpu_op_e'($urandom_range(int'(hcpu_pkg::OP_BRB)));
    end
    return {opc, nib};
  endfunction

  function automatic void check_field(input string name, input logic [15:0] exp_v,
                                      input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Drive one input transaction and record what it should produce
  task automatic send_item(input logic opn, input waddr_t la, input logic [15:0] ld,
                           input logic [15:0] idata, input bit typed,
                           input hcpu_pkg::hcpu_res_t typed_res);
    hcpu_pkg::hcpu_res_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= opn;
    load_addr_i <= la;
    load_data_i <= ld;
    in_data_i   <= idata;
    do @(posedge clk_i); while (in_stall_o);
    pred = step_processor(opn, la, ld, idata);
    pending_results.push_back(typed ? typed_res : pred);
    items_sent++;
  endtask

  // One execute item, after loading fetch word if unwritten or rewritten, data word if unwritten
  task automatic run_instruction(input bit rewrite, input bit typed,
                                 input hcpu_pkg::hcpu_res_t typed_res,
                                 input logic [15:0] idata);
    waddr_t      fw;
    waddr_t      dw;
    logic [15:0] word;
    logic [7:0]  ins;
    fw = cpu_pc[hcpu_pkg::WORD_ADDR_BITS:1];
    if (rewrite || !mem_written[fw]) begin
      ins = rewrite ? pick_ins() : 8'($urandom);
      word = mem_written[fw] ? mem_words[fw] : 16'($urandom);
      if (cpu_pc[0]) word[15:8] = ins;
      else word[7:0] = ins;
      send_item(hcpu_pkg::OPN_LOAD, fw, word, 16'($urandom), 1'b0, '0);
    end
    if (reads_data(fetch_byte(), dw) && !mem_written[dw])
      send_item(hcpu_pkg::OPN_LOAD, dw, 16'($urandom), 16'($urandom), 1'b0, '0);
    send_item(hcpu_pkg::OPN_EXEC, waddr_t'($urandom), 16'($urandom), idata, typed,
              typed_res);
  endtask

  // Receiver stalls
  always @(posedge clk_i) begin
    res_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Result checker
  always @(posedge clk_i) begin
    hcpu_pkg::hcpu_res_t exp_res;
    if (rst_ni && res_valid_o && !res_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual pc=%h acc=%h", $time,
                 pc_now_o, acc_now_o);
        errors++;
      end else begin
        exp_res = pending_results.pop_front();
        check_field("pc_now", exp_res.pc, pc_now_o);
        check_field("acc_now", exp_res.acc, acc_now_o);
        check_field("out_valid", exp_res.out_valid, out_valid_o);
        check_field("out_byte", exp_res.out_byte, out_byte_o);
        check_field("io_port", exp_res.io_port, io_port_o);
        check_field("in_taken", exp_res.in_taken, in_taken_o);
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (res_valid_o && !res_stall_i)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  // Stimulus
  initial begin
    stim_row_t row;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed program
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = DIR_TAB[i];
      if (row.opn == hcpu_pkg::OPN_LOAD)
        send_item(row.opn, row.addr, row.data, row.in_val, row.typed,
                  {row.exp_pc, row.exp_acc, 1'b0, 8'h00, 16'h0000, 1'b0});
      else
        run_instruction(1'b0, row.typed,
                        {row.exp_pc, row.exp_acc, 1'b0, 8'h00, 16'h0000, 1'b0}, row.in_val);
    end

    // random programs, one idling pattern per phase
    for (int ph = 0; ph < 4; ph++) begin
      // hold the sender until every transaction has drained
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while (pending_results.size() != 0);
      send_idle_pct = SEND_IDLE[ph];
      stall_pct = RECV_STALL[ph];
      while (items_sent < DIR_ROWS + (ph + 1) * PHASE_ITEMS) begin
        if ($urandom_range(99) < 10)
          send_item(hcpu_pkg::OPN_LOAD, waddr_t'($urandom), 16'($urandom), 16'($urandom),
                    1'b0, '0);
        else
          run_instruction($urandom_range(99) < 80, 1'b0, '0,
                          ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom));
      end
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
